// ----- hdl/jcs_pkg.sv -----
package jcs_pkg;

	// default width of positions and lengths
	localparam int LENGTH_BITS_DEF = 24;

	// marker codes following an FF prefix
	localparam logic [7:0] MK_PREFIX = 8'hFF;
	localparam logic [7:0] MK_SOC    = 8'h4F;
	localparam logic [7:0] MK_SOT    = 8'h90;
	localparam logic [7:0] MK_EOC    = 8'hD9;
	localparam logic [7:0] MK_COM    = 8'h64;

	// buffers shorter than this pass untouched
	localparam int MIN_BUFFER_LEN = 6;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	// master tdata: out_byte, comment_removed, run_end, zero pad
	localparam int M_DATA_W    = 16;
	localparam int M_PAD_W     = M_DATA_W - 10;
	localparam int M_REMOVED_B = 8;
	localparam int M_RUN_END_B = 9;

	typedef enum logic [2:0] {
		PH_SCANNING,
		PH_PASSING,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_BODY
	} phase_t;

	typedef struct packed {
		logic       run_end;
		logic       removed;
		logic       done;
		logic       valid;
		logic [7:0] data;
	} res_t;

endpackage

// ----- hdl/jcs_res_fifo.sv -----
module jcs_res_fifo
	import jcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  res_t       push0,
	input  res_t       push1,
	output logic       room,
	output logic       out_valid,
	output res_t       out_data,
	input  logic       out_ready
);

	res_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;
	logic [FIFO_PTR_W-1:0] wr_next;

	assign room      = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign wr_next   = wr_q + FIFO_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_next] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_PTR_W'(push_n);
			rd_q  <= rd_q + FIFO_PTR_W'(pop);
			cnt_q <= cnt_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
		end
	end

endmodule

// ----- hdl/jcs_core.sv -----
module jcs_core
	import jcs_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	input  logic [LENGTH_BITS-1:0] buffer_length,
	input  logic                   end_of_buffer,
	output logic [1:0]             res_n,
	output res_t                   res0,
	output res_t                   res1
);

	localparam int LW1 = LENGTH_BITS + 1;
	localparam int TW  = ((LENGTH_BITS > 17) ? LENGTH_BITS : 17) + 1;

	phase_t                 phase_q, phase_n, phase_eff;
	logic                   held_q, held_n;
	logic                   hdr_q, hdr_n;
	logic [LENGTH_BITS-1:0] pos_q, pos_n;
	logic [LENGTH_BITS-1:0] len_q, len_n, len_eff;
	logic [7:0]             hi_q, hi_n;
	logic [LENGTH_BITS-1:0] skip_q, skip_n, skip_dec;
	logic                   removed_q, removed_n, removed_step;

	logic                   pos_zero;
	logic [LENGTH_BITS-1:0] pos_prev;
	logic                   com_hit;
	logic                   com_fire;
	logic [TW-1:0]          total, skip_ext, tot_c;
	logic                   b_is_ff;

	assign pos_zero  = pos_q == '0;
	assign len_eff   = pos_zero ? buffer_length : len_q;
	assign phase_eff = (pos_zero && buffer_length < LENGTH_BITS'(MIN_BUFFER_LEN))
		? PH_PASSING : phase_q;
	assign pos_prev  = pos_q - LENGTH_BITS'(1);
	assign b_is_ff   = data_byte == MK_PREFIX;
	assign com_hit   = data_byte == MK_COM && hdr_q
		&& ({1'b0, pos_prev} + LW1'(4) <= {1'b0, len_eff});
	assign com_fire     = phase_eff == PH_SCANNING && held_q && com_hit;
	assign removed_step = removed_q || com_fire;

	// comment length plus marker, clamped to what is left of the buffer
	assign total    = TW'({hi_q, data_byte}) + TW'(2);
	assign skip_ext = TW'(skip_q);
	assign tot_c    = (total > skip_ext) ? skip_ext : total;
	assign skip_dec = (skip_q != '0) ? skip_q - LENGTH_BITS'(1) : skip_q;

	// next state
	always_comb begin
		phase_n   = phase_eff;
		held_n    = held_q;
		hdr_n     = hdr_q;
		pos_n     = pos_q + LENGTH_BITS'(1);
		len_n     = len_eff;
		hi_n      = hi_q;
		skip_n    = skip_q;
		removed_n = removed_step;
		case (phase_eff)
			PH_SCANNING: begin
				if (held_q) begin
					held_n = 1'b0;
					if (com_hit) begin
						skip_n  = len_eff - pos_prev;
						phase_n = PH_LEN_HI;
					end else if (b_is_ff) begin
						held_n = !end_of_buffer;
					end else if (data_byte == MK_SOC) begin
						hdr_n = 1'b1;
					end else if (data_byte == MK_SOT || data_byte == MK_EOC) begin
						phase_n = PH_PASSING;
					end
				end else if (b_is_ff && !end_of_buffer) begin
					held_n = 1'b1;
				end
			end
			PH_LEN_HI: begin
				hi_n    = data_byte;
				phase_n = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (tot_c <= TW'(4)) begin
					skip_n  = '0;
					phase_n = PH_PASSING;
				end else begin
					skip_n  = LENGTH_BITS'(tot_c - TW'(4));
					phase_n = PH_BODY;
				end
			end
			PH_BODY: begin
				skip_n = skip_dec;
				if (skip_dec == '0) begin
					phase_n = PH_PASSING;
				end
			end
			default: ;
		endcase
		if (end_of_buffer) begin
			phase_n   = PH_SCANNING;
			held_n    = 1'b0;
			hdr_n     = 1'b0;
			pos_n     = '0;
			len_n     = '0;
			hi_n      = '0;
			skip_n    = '0;
			removed_n = 1'b0;
		end
	end

	// results
	always_comb begin
		logic [1:0] n;
		logic [7:0] d0, d1;
		logic       v0;
		n  = 2'd0;
		d0 = data_byte;
		d1 = data_byte;
		v0 = 1'b1;
		case (phase_eff)
			PH_SCANNING: begin
				if (held_q) begin
					if (!com_hit) begin
						d0 = MK_PREFIX;
						n  = (b_is_ff && !end_of_buffer) ? 2'd1 : 2'd2;
					end
				end else if (!(b_is_ff && !end_of_buffer)) begin
					n = 2'd1;
				end
			end
			PH_LEN_LO: begin
				if (tot_c <= TW'(2)) begin
					d0 = hi_q;
					n  = 2'd2;
				end else if (tot_c == TW'(3)) begin
					n = 2'd1;
				end
			end
			PH_LEN_HI, PH_BODY: ;
			default: n = 2'd1;
		endcase
		if (end_of_buffer && n == 2'd0) begin
			n  = 2'd1;
			d0 = '0;
			v0 = 1'b0;
		end
		res_n        = n;
		res0.data    = d0;
		res0.valid   = v0;
		res0.done    = end_of_buffer && n == 2'd1;
		res0.removed = removed_step;
		res0.run_end = n == 2'd1;
		res1.data    = d1;
		res1.valid   = 1'b1;
		res1.done    = end_of_buffer;
		res1.removed = removed_step;
		res1.run_end = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SCANNING;
			held_q    <= 1'b0;
			hdr_q     <= 1'b0;
			pos_q     <= '0;
			len_q     <= '0;
			hi_q      <= '0;
			skip_q    <= '0;
			removed_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			held_q    <= held_n;
			hdr_q     <= hdr_n;
			pos_q     <= pos_n;
			len_q     <= len_n;
			hi_q      <= hi_n;
			skip_q    <= skip_n;
			removed_q <= removed_n;
		end
	end

endmodule

// ----- hdl/jpeg2000_comment_stripper_top.sv -----
// JPEG2000 comment stripper: removes the first COM segment (FF 64) of a codestream.
// Input stream (s_*): one codestream byte per item. tdata carries the byte in
//   [7:0] and the buffer length above it; the length is sampled on the first
//   byte of each buffer. tlast marks the final byte of the buffer.
// Output stream (m_*): one output byte per item. An input item yields zero,
//   one or two output items: an FF is held until the next byte, and the final
//   byte of a buffer always yields at least a bare end item (tuser low).
// Path: an accepted byte is held in the input register, is worked on there by
//   the combinational core and lands in a four-entry result queue; its first
//   result is offered on m_tvalid the cycle after it is written to the queue.
// Throughput: one input item per clock while m_tready stays high and each item
//   yields at most one result; items yielding two (a released FF plus its
//   follower) fill the queue faster than the single-item-per-cycle port drains it.
// Stall: when the receiver drops m_tready the queue fills; once fewer than
//   two free entries remain the input register holds and s_tready falls.
// Reset: asynchronous, clears queue pointers and all per-buffer scan state;
//   scan state also returns to idle after every byte marked tlast.
module jpeg2000_comment_stripper_top
	import jcs_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// [7:0] data_byte, [LENGTH_BITS+7:8] buffer_length, zero pad above
	input  logic [((8 + LENGTH_BITS + 7) / 8) * 8-1:0] s_tdata,
	input  logic                                    s_tlast,   // end_of_buffer
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// [7:0] out_byte, [8] comment_removed, [9] run_end, zero pad above
	output logic [M_DATA_W-1:0]                     m_tdata,
	output logic                                    m_tuser,   // byte_valid
	output logic                                    m_tlast    // buffer_done
);

	// input register
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic [LENGTH_BITS-1:0] len_s1;
	logic                   eob_s1;

	logic                   adv;
	logic                   room;
	logic [1:0]             res_n;
	logic [1:0]             push_n;
	res_t                   res0, res1, head;

	// the input register moves on only while the queue can take two results
	assign adv      = valid_s1 && room;
	assign s_tready = !valid_s1 || room;
	assign push_n   = adv ? res_n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			len_s1  <= s_tdata[8 +: LENGTH_BITS];
			eob_s1  <= s_tlast;
		end
	end

	jcs_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.data_byte    (byte_s1),
		.buffer_length(len_s1),
		.end_of_buffer(eob_s1),
		.res_n        (res_n),
		.res0         (res0),
		.res1         (res1)
	);

	jcs_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.push0    (res0),
		.push1    (res1),
		.room     (room),
		.out_valid(m_tvalid),
		.out_data (head),
		.out_ready(m_tready)
	);

	assign m_tdata = {{M_PAD_W{1'b0}}, head.run_end, head.removed, head.data};
	assign m_tuser = head.valid;
	assign m_tlast = head.done;

	// the last byte of a buffer always yields at least one result
	a_eob_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eob_s1 |-> res_n != 2'd0)
		else $error("end of buffer produced no result");

	// buffer end is always the last result of its input item
	a_done_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[M_RUN_END_B])
		else $error("buffer_done without run_end");

	// a bare end item carries no byte and closes the buffer
	a_bare_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata[7:0] == 8'h00)
		else $error("bare item not a clean buffer end");

	// a pushed pair always ends with the run_end result
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd2 |-> !res0.run_end && res1.run_end)
		else $error("two results with wrong run_end marking");

endmodule
